[rtl/core/i2cbm_pkg.sv]
// shared command codes, constants and result type for the i2c bit engine
package i2cbm_pkg;

    localparam logic [2:0] CMD_START = 3'd0;
    localparam logic [2:0] CMD_STOP  = 3'd1;
    localparam logic [2:0] CMD_WRITE = 3'd2;
    localparam logic [2:0] CMD_RDACK = 3'd3;
    localparam logic [2:0] CMD_READ  = 3'd4;
    localparam logic [2:0] CMD_ACK   = 3'd5;
    localparam logic [2:0] CMD_NACK  = 3'd6;

    localparam logic [7:0] PHASE_DELAY_RESET = 8'd100;
    localparam logic [2:0] LAST_BIT          = 3'd7;

    typedef struct packed {
        logic       scl_level;
        logic       sda_level;
        logic       sda_driven;
        logic       busy;
        logic       done;
        logic [7:0] rx_byte;
        logic       nack_seen;
    } res_t;

    // number of scl/sda phases in one pass of a command
    function automatic logic [1:0] phase_count(input logic [2:0] cmd);
        logic [1:0] n;
        case (cmd)
            CMD_STOP, CMD_READ: n = 2'd2;
            CMD_START, CMD_WRITE, CMD_RDACK, CMD_ACK, CMD_NACK: n = 2'd3;
            default: n = 2'd0;
        endcase
        return n;
    endfunction

endpackage

[rtl/core/i2c_bit_level_master.sv]
// I2C master bit engine: each item is one time-base tick carrying the sampled sda
// level and an optional command (start, stop, write byte, read ack, read byte,
// send ack, send nack). One item is taken per clock cycle while tick_stall is low;
// its result (pin levels, busy, done, last received byte, ack sample) sits in the
// result register in the cycle after the item is taken. The result register is
// the only buffer, so a stall on the result side holds off new ticks only while
// it is full and not being taken. Each scl/sda phase lasts phase_delay ticks, not
// clock cycles (0 acts as 1); a new phase_delay takes effect at the next phase.
module i2c_bit_level_master (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic [7:0] cfg_data,
    input  logic       tick_valid,
    output logic       tick_stall,
    input  logic       cmd_valid,
    input  logic [2:0] command,
    input  logic [7:0] tx_byte,
    input  logic       sda_in,
    output logic       res_valid,
    input  logic       res_stall,
    output logic       scl_level,
    output logic       sda_level,
    output logic       sda_driven,
    output logic       busy_res,
    output logic       done_res,
    output logic [7:0] rx_byte,
    output logic       nack_seen
);
    import i2cbm_pkg::*;

    logic [7:0] phase_delay_reg;
    logic       valid_reg;
    res_t       res_reg;
    res_t       res_next;
    logic       accept;

    assign tick_stall = valid_reg & res_stall;
    assign accept     = tick_valid & ~tick_stall;

    i2cbm_engine u_engine (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (accept),
        .cmd_valid   (cmd_valid),
        .command     (command),
        .tx_byte     (tx_byte),
        .sda_in      (sda_in),
        .phase_delay (phase_delay_reg),
        .res_next    (res_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_delay_reg <= PHASE_DELAY_RESET;
            valid_reg       <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                phase_delay_reg <= cfg_data;
            if (accept)
                valid_reg <= 1'b1;
            else if (!res_stall)
                valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            res_reg <= res_next;
    end

    assign res_valid  = valid_reg;
    assign scl_level  = res_reg.scl_level;
    assign sda_level  = res_reg.sda_level;
    assign sda_driven = res_reg.sda_driven;
    assign busy_res   = res_reg.busy;
    assign done_res   = res_reg.done;
    assign rx_byte    = res_reg.rx_byte;
    assign nack_seen  = res_reg.nack_seen;

    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && done_res |-> busy_res)
        else $error("done without busy");

    a_accept_shows: assert property (@(posedge clk) disable iff (!rst_n)
        tick_valid && !tick_stall |=> res_valid)
        else $error("taken item has no result");

    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_stall && !tick_valid |=> !res_valid)
        else $error("result repeated");

endmodule

[rtl/core/i2cbm_engine.sv]
// phase sequencer state and its one-tick next-state logic
module i2cbm_engine (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  logic              cmd_valid,
    input  logic [2:0]        command,
    input  logic [7:0]        tx_byte,
    input  logic              sda_in,
    input  logic [7:0]        phase_delay,
    output i2cbm_pkg::res_t   res_next
);
    import i2cbm_pkg::*;

    logic [2:0] act_reg, act_next;
    logic       run_reg, run_next;
    logic [1:0] ph_reg, ph_next;
    logic [7:0] tc_reg, tc_next;
    logic [2:0] bc_reg, bc_next;
    logic [7:0] sh_reg, sh_next;
    logic       scl_reg, scl_next;
    logic       sda_reg, sda_next;
    logic       dir_reg, dir_next;
    logic       ack_reg, ack_next;
    logic [7:0] rx_reg, rx_next;

    logic       done;
    logic       enter;
    logic [7:0] tc_dec;
    logic [2:0] ph_inc;

    always_comb
    begin
        act_next = act_reg;
        run_next = run_reg;
        ph_next  = ph_reg;
        tc_next  = tc_reg;
        bc_next  = bc_reg;
        sh_next  = sh_reg;
        scl_next = scl_reg;
        sda_next = sda_reg;
        dir_next = dir_reg;
        ack_next = ack_reg;
        rx_next  = rx_reg;
        done     = 1'b0;
        enter    = 1'b0;
        tc_dec   = tc_reg - 8'd1;
        ph_inc   = {1'b0, ph_reg} + 3'd1;

        if (run_reg)
        begin
            tc_next = tc_dec;
            if (tc_dec == 8'd0)
            begin
                // end of phase: samples use this tick's sda
                if (act_reg == CMD_RDACK && ph_reg == 2'd1)
                    ack_next = sda_in;
                if (act_reg == CMD_READ && ph_reg == 2'd0)
                    sh_next = {sh_reg[6:0], sda_in};
                if (act_reg == CMD_ACK && ph_reg == 2'd2)
                    sda_next = 1'b1;
                if (ph_inc < {1'b0, phase_count(act_reg)})
                begin
                    ph_next = ph_inc[1:0];
                    enter   = 1'b1;
                end
                else if (act_reg == CMD_WRITE || act_reg == CMD_READ)
                begin
                    if (bc_reg == LAST_BIT)
                    begin
                        if (act_reg == CMD_READ)
                            rx_next = sh_next;
                        run_next = 1'b0;
                        done     = 1'b1;
                    end
                    else
                    begin
                        bc_next = bc_reg + 3'd1;
                        ph_next = 2'd0;
                        enter   = 1'b1;
                    end
                end
                else
                begin
                    run_next = 1'b0;
                    done     = 1'b1;
                end
            end
        end
        else if (cmd_valid && command <= CMD_NACK)
        begin
            act_next = command;
            run_next = 1'b1;
            ph_next  = 2'd0;
            bc_next  = 3'd0;
            enter    = 1'b1;
            if (command == CMD_WRITE)
            begin
                dir_next = 1'b1;
                sh_next  = tx_byte;
            end
            if (command == CMD_READ)
            begin
                dir_next = 1'b0;
                sh_next  = 8'd0;
            end
        end

        if (enter)
        begin
            case (act_next)
                CMD_START:
                begin
                    if (ph_next == 2'd0)
                    begin
                        dir_next = 1'b1;
                        sda_next = 1'b1;
                        scl_next = 1'b1;
                    end
                    else if (ph_next == 2'd1)
                        sda_next = 1'b0;
                    else
                        scl_next = 1'b0;
                end
                CMD_STOP:
                begin
                    if (ph_next == 2'd0)
                    begin
                        dir_next = 1'b1;
                        sda_next = 1'b0;
                        scl_next = 1'b1;
                    end
                    else
                        sda_next = 1'b1;
                end
                CMD_WRITE:
                begin
                    if (ph_next == 2'd0)
                        sda_next = sh_next[7];
                    else if (ph_next == 2'd1)
                        scl_next = 1'b1;
                    else
                    begin
                        scl_next = 1'b0;
                        // release sda after the eighth bit
                        if (bc_next == LAST_BIT)
                            sda_next = 1'b1;
                        sh_next = {sh_next[6:0], 1'b0};
                    end
                end
                CMD_RDACK:
                begin
                    if (ph_next == 2'd0)
                    begin
                        dir_next = 1'b0;
                        sda_next = 1'b1;
                    end
                    else if (ph_next == 2'd1)
                        scl_next = 1'b1;
                    else
                        scl_next = 1'b0;
                end
                CMD_READ:
                begin
                    scl_next = (ph_next == 2'd0);
                end
                default:
                begin
                    // send ack or nack
                    if (ph_next == 2'd0)
                    begin
                        dir_next = 1'b1;
                        sda_next = (act_next != CMD_ACK);
                    end
                    else if (ph_next == 2'd1)
                        scl_next = 1'b1;
                    else
                        scl_next = 1'b0;
                end
            endcase
            tc_next = (phase_delay == 8'd0) ? 8'd1 : phase_delay;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            act_reg <= CMD_START;
            run_reg <= 1'b0;
            ph_reg  <= 2'd0;
            tc_reg  <= 8'd0;
            bc_reg  <= 3'd0;
            sh_reg  <= 8'd0;
            scl_reg <= 1'b1;
            sda_reg <= 1'b1;
            dir_reg <= 1'b1;
            ack_reg <= 1'b0;
            rx_reg  <= 8'd0;
        end
        else if (step)
        begin
            act_reg <= act_next;
            run_reg <= run_next;
            ph_reg  <= ph_next;
            tc_reg  <= tc_next;
            bc_reg  <= bc_next;
            sh_reg  <= sh_next;
            scl_reg <= scl_next;
            sda_reg <= sda_next;
            dir_reg <= dir_next;
            ack_reg <= ack_next;
            rx_reg  <= rx_next;
        end
    end

    always_comb
    begin
        res_next.scl_level  = scl_next;
        res_next.sda_level  = sda_next;
        res_next.sda_driven = dir_next;
        res_next.busy       = run_next | done;
        res_next.done       = done;
        res_next.rx_byte    = rx_next;
        res_next.nack_seen  = ack_next;
    end

endmodule
